// ----- rtl/pkef_pkg.sv -----
package pkef_pkg;

  // Key codes seen on the panel link.
  localparam logic [6:0] KEY_MASK      = 7'h7F;
  localparam logic [6:0] KEY_APPEL     = 7'h04;
  localparam logic [6:0] KEY_PTT_PRESS = 7'h2E;
  localparam logic [6:0] KEY_ON_OFF    = 7'h60;

  // Bytes and display codes sent back to the panel.
  localparam logic [6:0] FRAME_START = 7'h78;
  localparam logic [6:0] POWER_OFF   = 7'h6A;
  localparam logic [6:0] CODE_SPACE  = 7'h24;
  localparam logic [6:0] CODE_A      = 7'h0A;
  localparam logic [6:0] CODE_B      = 7'h25;
  localparam logic [6:0] CODE_C      = 7'h10;
  localparam logic [6:0] CODE_D      = 7'h0D;
  localparam logic [6:0] CODE_E      = 7'h0E;
  localparam logic [6:0] CODE_F      = 7'h27;
  localparam logic [6:0] CODE_K      = 7'h14;
  localparam logic [6:0] CODE_Y      = 7'h22;

  // Run lengths: power-off bytes before the frame, and the frame itself.
  localparam int OFF_RUN_LEN = 10;
  localparam int FRAME_LEN   = 9;
  localparam int IDX_W       = 5;
  localparam int POS_W       = 4;

  localparam logic [IDX_W-1:0] LAST_IDX_KEY = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] LAST_IDX_OFF = IDX_W'(OFF_RUN_LEN + FRAME_LEN - 1);

  // One byte of a run, handed from the frame generator to the output stage.
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } seq_byte_t;

  // Display code of one hex digit.
  function automatic logic [6:0] hex_code(input logic [3:0] nib);
    logic [6:0] c;
    case (nib)
      4'hA:    c = CODE_A;
      4'hB:    c = CODE_B;
      4'hC:    c = CODE_C;
      4'hD:    c = CODE_D;
      4'hE:    c = CODE_E;
      4'hF:    c = CODE_F;
      default: c = {3'b000, nib};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/pkef_frame_gen.sv -----
module pkef_frame_gen (
  input  logic                     off,
  input  logic [6:0]               key,
  input  logic [pkef_pkg::IDX_W-1:0] idx,
  output pkef_pkg::seq_byte_t      byte_o
);
  import pkef_pkg::*;

  logic [IDX_W-1:0] pos_full;
  logic [POS_W-1:0] pos;
  logic [6:0]       data;

  // Position inside the frame; the power-off bytes come ahead of it.
  assign pos_full = off ? (idx - IDX_W'(OFF_RUN_LEN)) : idx;
  assign pos      = pos_full[POS_W-1:0];

  // Frame bytes: start code, then text characters 7,3,6,2,5,1,4,0.
  always_comb begin
    data = FRAME_START;
    if (off && (idx < IDX_W'(OFF_RUN_LEN))) begin
      data = POWER_OFF;
    end else if (off) begin
      case (pos)
        4'd0:    data = FRAME_START;
        4'd1:    data = CODE_SPACE;
        4'd2:    data = CODE_SPACE;
        4'd3:    data = CODE_E;
        4'd4:    data = CODE_E;
        4'd5:    data = CODE_Y;
        4'd6:    data = CODE_Y;
        4'd7:    data = CODE_B;
        4'd8:    data = CODE_B;
        default: data = FRAME_START;
      endcase
    end else begin
      case (pos)
        4'd0:    data = FRAME_START;
        4'd1:    data = CODE_SPACE;
        4'd2:    data = CODE_SPACE;
        4'd3:    data = CODE_SPACE;
        4'd4:    data = CODE_Y;
        4'd5:    data = hex_code(key[3:0]);
        4'd6:    data = CODE_E;
        4'd7:    data = hex_code({1'b0, key[6:4]});
        4'd8:    data = CODE_K;
        default: data = FRAME_START;
      endcase
    end
  end

  // Even parity goes in bit 7.
  assign byte_o.tx   = {^data, data};
  assign byte_o.last = off ? (idx == LAST_IDX_OFF) : (idx == LAST_IDX_KEY);

endmodule

// ----- rtl/panel_key_echo_framer.sv -----
// A key request goes from the input register to the run sequencer to the output register.
// Throughput: one byte per cycle while out_ready allows; a key run is 9 bytes, the on/off
// run 19 bytes, set by the byte counter of the frame sequencer. The next key is held in an
// input register and starts right after the last byte of the current run, unless halted.
// Reset (rst_n low, synchronous) clears all valid flags and the halted flag.
module panel_key_echo_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last
);
  import pkef_pkg::*;

  logic             pend_valid_r;
  logic [6:0]       pend_key_r;
  logic             cur_active_r;
  logic             cur_off_r;
  logic [6:0]       cur_key_r;
  logic [IDX_W-1:0] idx_r;
  logic             halted_r;
  logic             out_valid_r;
  logic [7:0]       out_tx_r;
  logic             out_last_r;

  logic [6:0]       in_key;
  logic             in_take;
  logic             step;
  logic             cur_free;
  logic             pend_take;
  logic             cur_load;
  seq_byte_t        gen_byte;

  // Key code of the incoming request, with APPEL remapped.
  always_comb begin
    in_key = in_rx_byte[6:0] & KEY_MASK;
    if (in_key == KEY_APPEL) begin
      in_key = KEY_PTT_PRESS;
    end
  end

  pkef_frame_gen u_gen (
    .off    (cur_off_r),
    .key    (cur_key_r),
    .idx    (idx_r),
    .byte_o (gen_byte)
  );

  // Handshake and sequencing control.
  assign step      = cur_active_r && (!out_valid_r || out_ready);
  assign cur_free  = !cur_active_r || (step && gen_byte.last);
  assign pend_take = pend_valid_r && (halted_r || cur_free);
  assign cur_load  = pend_take && !halted_r;
  assign in_ready  = !pend_valid_r || pend_take;
  assign in_take   = in_valid && in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_take) begin
      pend_valid_r <= 1'b1;
    end else if (pend_take) begin
      pend_valid_r <= 1'b0;
    end
    if (in_take) begin
      pend_key_r <= in_key;
    end
  end

  // Run sequencer and halted flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_active_r <= 1'b0;
      halted_r     <= 1'b0;
      idx_r        <= '0;
    end else if (cur_load) begin
      cur_active_r <= 1'b1;
      idx_r        <= '0;
      if (pend_key_r == KEY_ON_OFF) begin
        halted_r <= 1'b1;
      end
    end else if (step) begin
      if (gen_byte.last) begin
        cur_active_r <= 1'b0;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (cur_load) begin
      cur_off_r <= (pend_key_r == KEY_ON_OFF);
      cur_key_r <= pend_key_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (step) begin
      out_tx_r   <= gen_byte.tx;
      out_last_r <= gen_byte.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_tx_r;
  assign out_last    = out_last_r;

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted flag cleared without reset");

  // The byte counter never runs past the end of its run.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_active_r |-> (idx_r <= (cur_off_r ? LAST_IDX_OFF : LAST_IDX_KEY)))
    else $error("byte counter beyond end of run");

  // While halted, only the on/off run may still be in progress.
  a_halt_run: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !(cur_active_r && !cur_off_r))
    else $error("key run active while halted");

  // No new run starts while halted.
  a_no_load_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !cur_active_r) |=> !cur_active_r)
    else $error("run started while halted");

endmodule
